@@ rtl/core/xmoe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_pkg
// Shared constants and types for the memory operand encoder.
// ----------------------------------------------------------------------------
package xmoe_pkg;

    localparam int unsigned MaxBytes = 6;
    localparam int unsigned CntW     = $clog2(MaxBytes + 1);

    // addressing modes
    localparam logic [1:0] MODE_DISP      = 2'd0;
    localparam logic [1:0] MODE_BASE      = 2'd1;
    localparam logic [1:0] MODE_BASE_IDX  = 2'd2;
    localparam logic [1:0] MODE_IDX       = 2'd3;

    // ModRM / SIB register field codes
    localparam logic [2:0] RM_SP = 3'b100;
    localparam logic [2:0] RM_BP = 3'b101;

    // ModRM mod codes
    localparam logic [1:0] MOD_NODISP = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP32 = 2'b10;

    localparam logic [7:0] SIB_SP_BASE = 8'h24;

    // one assembled operand, byte 0 first
    typedef struct packed {
        logic [8*MaxBytes-1:0] bytes;
        logic [MaxBytes-1:0]   disp_mask;
        logic [CntW-1:0]       count;
        logic                  err;
    } t_enc_item;

endpackage
`default_nettype wire

@@ rtl/core/x86_memory_operand_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86_memory_operand_encoder
// Encodes one memory operand into ModRM, optional SIB and displacement bytes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_stall     mode, reg, base, index, scale, disp
//  out       output     o_out_valid / i_out_stall   code byte, disp flag, last, error
//  cfg       input      i_cfg_valid / o_cfg_ready   short displacement enable
//
//  An operand passes three register stages (capture, encode decision, byte
//  assembly) and then the output register. It leaves there at one byte per
//  cycle while the output is not stalled: an operand of N bytes (1 to 6)
//  occupies the byte-wide output register until its last byte is taken,
//  which sets the sustained rate; the stages ahead keep filling meanwhile.
//  Synchronous active-low reset empties all stages and sets the short
//  displacement enable. A stall on the output holds every full stage in place.
// ----------------------------------------------------------------------------
module x86_memory_operand_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // operand input
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_addressing_mode,
    input  wire logic [2:0]  i_reg_code,
    input  wire logic [2:0]  i_base_low,
    input  wire logic [2:0]  i_index_low,
    input  wire logic [1:0]  i_scale_code,
    input  wire logic signed [31:0] i_displacement,
    // byte output
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_code_byte,
    output logic             o_is_displacement,
    output logic             o_last_byte,
    output logic             o_index_error,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);
    import xmoe_pkg::*;

    // configuration register
    logic r_short_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_short_en <= i_cfg_data;
        end
    end

    // stage valids and flow control
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic w_ser_ready;
    logic w_s3_free, w_s2_free, w_s1_free;

    // a stage may take new data when empty or when its content moves on
    assign w_s3_free  = !r_s3_valid || w_ser_ready;
    assign w_s2_free  = !r_s2_valid || w_s3_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_in_stall = !w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // ---------------- stage 1: capture the operand fields ----------------
    logic [1:0]  r_s1_mode;
    logic [2:0]  r_s1_reg, r_s1_base, r_s1_idx;
    logic [1:0]  r_s1_scale;
    logic [31:0] r_s1_disp;

    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_mode  <= i_addressing_mode;
            r_s1_reg   <= i_reg_code;
            r_s1_base  <= i_base_low;
            r_s1_idx   <= i_index_low;
            r_s1_scale <= i_scale_code;
            r_s1_disp  <= i_displacement;
        end
    end

    // ---------------- stage 2: choose mod, rm, SIB and disp size ----------------
    logic [1:0]  n_mod;
    logic [2:0]  n_rm;
    logic        n_has_sib;
    logic [7:0]  n_sib;
    logic [2:0]  n_disp_len;
    logic        n_err;
    logic        w_fits8;
    logic        w_disp_zero;
    logic [7:0]  w_sib_idx;

    // value fits a signed byte when bits 31..7 are all equal
    assign w_fits8     = (r_s1_disp[31:7] == '0) || (r_s1_disp[31:7] == '1);
    assign w_disp_zero = (r_s1_disp == '0);
    assign w_sib_idx   = {r_s1_scale, r_s1_idx, 3'b000};

    always_comb begin
        n_mod      = MOD_NODISP;
        n_rm       = RM_BP;
        n_has_sib  = 1'b0;
        n_sib      = 8'h00;
        n_disp_len = 3'd4;
        n_err      = 1'b0;
        unique case (r_s1_mode)
            MODE_DISP: begin
                n_mod      = MOD_NODISP;
                n_rm       = RM_BP;
                n_disp_len = 3'd4;
            end
            MODE_IDX: begin
                // no base: SIB base field 101 with mod 00 forces disp32
                n_mod      = MOD_NODISP;
                n_rm       = RM_SP;
                n_has_sib  = 1'b1;
                n_sib      = w_sib_idx | {5'b00000, RM_BP};
                n_disp_len = 3'd4;
                n_err      = (r_s1_idx == RM_SP);
            end
            MODE_BASE, MODE_BASE_IDX: begin
                // BP base with mod 00 would mean no base, so keep a displacement
                priority if (w_disp_zero && r_s1_base != RM_BP) begin
                    n_mod      = MOD_NODISP;
                    n_disp_len = 3'd0;
                end else if (r_short_en && w_fits8) begin
                    n_mod      = MOD_DISP8;
                    n_disp_len = 3'd1;
                end else begin
                    n_mod      = MOD_DISP32;
                    n_disp_len = 3'd4;
                end
                if (r_s1_mode == MODE_BASE) begin
                    n_rm = r_s1_base;
                    if (r_s1_base == RM_SP) begin
                        n_has_sib = 1'b1;
                        n_sib     = SIB_SP_BASE;
                    end
                end else begin
                    n_rm      = RM_SP;
                    n_has_sib = 1'b1;
                    n_sib     = w_sib_idx | {5'b00000, r_s1_base};
                    n_err     = (r_s1_idx == RM_SP);
                end
            end
            default: begin
                n_mod = MOD_NODISP;
            end
        endcase
    end

    logic [7:0]  r_s2_modrm;
    logic        r_s2_has_sib;
    logic [7:0]  r_s2_sib;
    logic [2:0]  r_s2_disp_len;
    logic        r_s2_err;
    logic [31:0] r_s2_disp;

    always_ff @(posedge i_clk) begin
        if (w_s2_free) begin
            r_s2_modrm    <= {n_mod, r_s1_reg, n_rm};
            r_s2_has_sib  <= n_has_sib;
            r_s2_sib      <= n_sib;
            r_s2_disp_len <= n_disp_len;
            r_s2_err      <= n_err;
            r_s2_disp     <= r_s1_disp;
        end
    end

    // ---------------- stage 3: assemble the byte string ----------------
    t_enc_item n_item;
    t_enc_item r_s3_item;

    always_comb begin
        n_item.err = r_s2_err;
        if (r_s2_has_sib) begin
            n_item.bytes     = {r_s2_disp, r_s2_sib, r_s2_modrm};
            n_item.disp_mask = 6'b111100;
            n_item.count     = CntW'(r_s2_disp_len) + CntW'(2);
        end else begin
            n_item.bytes     = {8'h00, r_s2_disp, r_s2_modrm};
            n_item.disp_mask = 6'b011110;
            n_item.count     = CntW'(r_s2_disp_len) + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_free) begin
            r_s3_item <= n_item;
        end
    end

    // ---------------- output register: one byte per transfer ----------------
    xmoe_serializer u_serializer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load_valid      (r_s3_valid),
        .i_item            (r_s3_item),
        .o_load_ready      (w_ser_ready),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_code_byte       (o_code_byte),
        .o_is_displacement (o_is_displacement),
        .o_last_byte       (o_last_byte),
        .o_index_error     (o_index_error)
    );

endmodule
`default_nettype wire

@@ rtl/core/xmoe_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_serializer
// Holds one assembled operand and sends it out one byte per transfer.
// ----------------------------------------------------------------------------
module xmoe_serializer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load_valid,
    input  wire xmoe_pkg::t_enc_item i_item,
    output logic                    o_load_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [7:0]              o_code_byte,
    output logic                    o_is_displacement,
    output logic                    o_last_byte,
    output logic                    o_index_error
);
    import xmoe_pkg::*;

    logic                  r_valid;
    logic [8*MaxBytes-1:0] r_buf;
    logic [MaxBytes-1:0]   r_mask;
    logic [CntW-1:0]       r_left;
    logic                  r_err;
    logic                  w_xfer;
    logic                  w_last;
    logic                  w_load;

    assign w_last       = (r_left == CntW'(1));
    assign w_xfer       = r_valid && !i_out_stall;
    assign o_load_ready = !r_valid || (w_xfer && w_last);
    assign w_load       = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (w_xfer && w_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf  <= i_item.bytes;
            r_mask <= i_item.disp_mask;
            r_left <= i_item.count;
            r_err  <= i_item.err;
        end else if (w_xfer) begin
            // advance to the next byte
            r_buf  <= {8'h00, r_buf[8*MaxBytes-1:8]};
            r_mask <= {1'b0, r_mask[MaxBytes-1:1]};
            r_left <= r_left - CntW'(1);
        end
    end

    assign o_out_valid       = r_valid;
    assign o_code_byte       = r_buf[7:0];
    assign o_is_displacement = r_mask[0];
    assign o_last_byte       = w_last;
    assign o_index_error     = r_err;

endmodule
`default_nettype wire

@@ rtl/core/xmoe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module xmoe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_code_byte,
    input wire logic       o_is_displacement,
    input wire logic       o_last_byte,
    input wire logic       o_index_error
);
    logic w_xfer_mid;

    assign w_xfer_mid = o_out_valid && !i_out_stall && !o_last_byte;

    // stalled byte holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_code_byte))
        else $error("stalled output byte changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an operand never breaks off before its last byte
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer_mid |=> o_out_valid)
        else $error("operand stream broke before last byte");

    // error flag is constant across one operand
    a_err_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer_mid |=> o_index_error == $past(o_index_error))
        else $error("index error changed within operand");

    // displacement bytes run to the end of the operand
    a_disp_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer_mid && o_is_displacement |=> o_is_displacement)
        else $error("non-displacement byte after displacement byte");

endmodule

bind x86_memory_operand_encoder xmoe_checker u_xmoe_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_code_byte       (o_code_byte),
    .o_is_displacement (o_is_displacement),
    .o_last_byte       (o_last_byte),
    .o_index_error     (o_index_error)
);
`default_nettype wire
